// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DefWidth = 32;
  localparam int FieldW   = 32;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_MUL   = 2'd1,
    MODE_RED   = 2'd2,
    MODE_RECIP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_RECIP_Z  = 2'd2,
    ST_OVF      = 2'd3
  } status_t;

  // Divider request and response.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== design/rau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels of the rational arithmetic unit.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [31:0] res_den;
  logic [31:0] whole_part;
  logic        proper_flag;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, whole_part, proper_flag, status,
                  input ready);
  modport sink   (input valid, res_num, res_den, whole_part, proper_flag, status,
                  output ready);
endinterface

// ===== design/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, multiply, reduce and reciprocal with GCD reduction.
// ----------------------------------------------------------------------------
// Usage:
//   in  : mode, a_num, a_den, b_num, b_den on a valid/ready channel.
//   out : res_num, res_den, whole_part, proper_flag, status.
//   One item is in flight at a time; in.ready is low from acceptance until
//   the result item is taken. An add or multiply item first forms its
//   products on the shared multiplier; add, multiply and reduce items then
//   take one pass of the shared restoring divider (2*WIDTH+2 bits) per
//   Euclid step, two more passes to divide out the GCD and one for the
//   quotient. The latency is data dependent; the divider sets the pace. A
//   reciprocal takes one pass, error cases skip the divider. Reset (rst,
//   synchronous) drops any item in flight and leaves the block ready. A
//   stalled receiver holds the result in the output register and the block
//   accepts nothing until it is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = DefWidth
) (
  input logic       clk,
  input logic       rst,
  rau_in_if.sink    in,
  rau_out_if.source out
);

  localparam int MW = 2 * WIDTH + 2;   // wide magnitude width

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL1  = 10'b0000000010,
    S_MUL2  = 10'b0000000100,
    S_MUL3  = 10'b0000001000,
    S_GCD   = 10'b0000010000,
    S_DIVN  = 10'b0000100000,
    S_DIVD  = 10'b0001000000,
    S_QUOT  = 10'b0010000000,
    S_WAIT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [1:0]       mode_r;
  logic             an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic [MW-1:0]    rn_m, rd_m, ga, gb, t1;
  logic             rn_s, rd_s, t1_s;
  logic [WIDTH-1:0] mx, my;
  logic [2*WIDTH-1:0] mp;
  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic [MW-1:0]    dvd, dvs, dq, dr;
  logic             phase;
  logic             div_go;

  // Field decode: low WIDTH bits, two's complement, split into sign and magnitude.
  function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
    logic [WIDTH-1:0] f;
    f = v[WIDTH-1:0];
    return f[WIDTH-1] ? (~f + 1'b1) : f;
  endfunction

  rau_mul #(.W(WIDTH)) u_mul (.clk(clk), .x(mx), .y(my), .p(mp));

  rau_div #(.W(MW)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quot(dq), .rem(dr)
  );

  // Multiplier operand select per step.
  always_comb begin
    unique case (state)
      S_MUL1:  begin mx = ad_m; my = bd_m; end
      S_MUL2:  begin mx = an_m; my = (mode_r == MODE_MUL) ? bn_m : bd_m; end
      default: begin mx = bn_m; my = ad_m; end
    endcase
  end

  // Launch a divider pass.
  always_comb begin
    unique case (state)
      S_MUL1:         div_go = (mode_r == MODE_RECIP) && (ad_m != '0) && (an_m != '0);
      S_GCD:          div_go = !phase;
      S_DIVN, S_DIVD: div_go = dsts.done;
      default:        div_go = 1'b0;
    endcase
  end

  logic [MW-1:0] mp_w;
  assign mp_w = {2'b00, mp};

  logic fit_n, fit_d, fit_q, q_neg, n_neg;
  logic [MW-1:0] lim;
  assign lim   = MW'(1) << (WIDTH - 1);
  assign fit_n = n_neg ? (rn_m <= lim) : (rn_m < lim);
  assign fit_d = rd_s ? (rd_m <= lim) : (rd_m < lim);
  assign q_neg = (dq != '0) && (n_neg != rd_s);
  assign fit_q = q_neg ? (dq <= lim) : (dq < lim);
  assign n_neg = rn_s && (rn_m != '0);

  logic [MW-1:0] qv, nv, dv;
  assign qv = q_neg ? (~dq + 1'b1) : dq;
  assign nv = n_neg ? (~rn_m + 1'b1) : rn_m;
  assign dv = rd_s ? (~rd_m + 1'b1) : rd_m;

  function automatic logic [31:0] sx(input logic [MW-1:0] v);
    return {{(32 - WIDTH){v[WIDTH-1]}}, v[WIDTH-1:0]};
  endfunction

  assign in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out.valid <= 1'b0;
      dctl      <= '0;
    end else begin
      dctl.start <= div_go;
      unique case (state)
        S_IDLE: if (in.valid) begin
          mode_r <= in.mode;
          an_s <= in.a_num[WIDTH-1]; an_m <= mag(in.a_num);
          ad_s <= in.a_den[WIDTH-1]; ad_m <= mag(in.a_den);
          bn_s <= in.b_num[WIDTH-1]; bn_m <= mag(in.b_num);
          bd_s <= in.b_den[WIDTH-1]; bd_m <= mag(in.b_den);
          state <= S_MUL1;
        end
        S_MUL1: begin
          out.res_num <= '0; out.res_den <= '0; out.whole_part <= '0;
          out.proper_flag <= 1'b0;
          if (ad_m == '0 || (mode_r[1] == 1'b0 && bd_m == '0)) begin
            out.status <= ST_ZERO_DEN;
            state <= S_OUT;
          end else if (mode_r == MODE_RECIP && an_m == '0) begin
            out.status <= ST_RECIP_Z;
            state <= S_OUT;
          end else if (mode_r[1]) begin
            // reduce / reciprocal need no products
            if (mode_r == MODE_RECIP) begin
              rn_m <= MW'(ad_m); rn_s <= ad_s; rd_m <= MW'(an_m); rd_s <= an_s;
              dvd <= MW'(ad_m); dvs <= MW'(an_m);
              state <= S_QUOT;
            end else begin
              rn_m <= MW'(an_m); rn_s <= an_s; rd_m <= MW'(ad_m); rd_s <= ad_s;
              ga <= MW'(an_m); gb <= MW'(ad_m);
              phase <= 1'b0;
              state <= S_GCD;
            end
          end else begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          rd_m <= mp_w; rd_s <= ad_s ^ bd_s;
          state <= S_MUL3;
        end
        S_MUL3: begin
          t1 <= mp_w;
          t1_s <= (mp_w != '0) && (an_s ^ (mode_r == MODE_MUL ? bn_s : bd_s));
          state <= (mode_r == MODE_MUL) ? S_WAIT : S_WAIT;
          phase <= 1'b0;
        end
        S_WAIT: begin
          // multiply: done; add: combine with bn*ad product now on mp
          if (mode_r == MODE_MUL) begin
            rn_m <= t1; rn_s <= t1_s; ga <= t1; gb <= rd_m;
          end else begin
            logic ys;
            logic [MW-1:0] sum;
            logic ss;
            ys = (mp_w != '0) && (bn_s ^ ad_s);
            if (t1_s == ys) begin sum = t1 + mp_w; ss = t1_s; end
            else if (t1 >= mp_w) begin sum = t1 - mp_w; ss = t1_s; end
            else begin sum = mp_w - t1; ss = ys; end
            rn_m <= sum; rn_s <= ss && (sum != '0); ga <= sum; gb <= rd_m;
          end
          state <= S_GCD;
        end
        S_GCD: begin
          // one Euclid step per divider pass
          if (!phase) begin
            if (gb == '0) begin
              dvd <= rn_m; dvs <= ga;
              state <= S_DIVN;
            end else begin
              dvd <= ga; dvs <= gb; phase <= 1'b1;
            end
          end else if (dsts.done) begin
            ga <= gb; gb <= dr; phase <= 1'b0;
          end
        end
        S_DIVN: if (dsts.done) begin
          rn_m <= dq;
          dvd <= rd_m; dvs <= ga;
          state <= S_DIVD;
        end
        S_DIVD: if (dsts.done) begin
          rd_m <= dq;
          dvd <= rn_m; dvs <= dq;
          state <= S_QUOT;
        end
        S_QUOT: if (dsts.done) begin
          if (!fit_n || !fit_d || !fit_q) begin
            out.status <= ST_OVF;
          end else begin
            out.status      <= ST_OK;
            out.res_num     <= sx(nv);
            out.res_den     <= sx(dv);
            out.whole_part  <= sx(qv);
            out.proper_flag <= rn_m < rd_m;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out.valid && out.ready) begin
            out.valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out.valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/rau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  div_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output div_sts_t     sts,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {rem, quot[W-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quot <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= shifted[W-1:0];
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== design/rau_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// Registered magnitude multiplier, shared by the cross-products.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [W-1:0]   x,
  input  logic [W-1:0]   y,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{W{1'b0}}, x} * {{W{1'b0}}, y};
  end

endmodule
